[rtl/i2c_master_register_access_core_defines.svh]
`ifndef I2C_MASTER_REGISTER_ACCESS_CORE_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define I2CM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/i2cm_pkg.sv]
package i2cm_pkg;

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST_HI, PH_ST_LO, PH_RS_LO, PH_WB_LO, PH_WB_HI, PH_ACK_LO,
      PH_ACK_WAIT, PH_NEED, PH_RB_LO, PH_RB_HI, PH_MA_LO, PH_MA_HI, PH_SP_LO,
      PH_SP_HI
   } phase_type;

   typedef enum logic [1:0] {KIND_ADDR, KIND_REG, KIND_DATA, KIND_RADDR} kind_type;

   typedef enum logic [1:0] {OP_TICK, OP_WRITE, OP_READ, OP_DATA} op_type;

   typedef enum logic [1:0] {ERR_NONE, ERR_ADDR, ERR_REG, ERR_DATA} err_type;

   typedef enum logic [1:0] {
      CSR_DEVICE_ADDRESS, CSR_HALF_PERIOD_TICKS, CSR_READ_LOW_TICKS, CSR_ACK_TIMEOUT_TICKS
   } csr_type;

   localparam int MAX_BYTES = 255;

   localparam logic [7:0]  DEVICE_ADDRESS_RESET    = 8'd0;
   localparam logic [15:0] HALF_PERIOD_TICKS_RESET = 16'd10;
   localparam logic [15:0] READ_LOW_TICKS_RESET    = 16'd30;
   localparam logic [7:0]  ACK_TIMEOUT_TICKS_RESET = 8'd250;

   typedef struct packed {
      logic [7:0]  device_address;
      logic [15:0] half_period_ticks;
      logic [15:0] read_low_ticks;
      logic [7:0]  ack_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] register_number;
      logic [7:0] byte_count;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       need_data;
      logic [7:0] read_data;
      logic       read_valid;
      logic       read_last;
      logic       done_res;
      err_type    error_code;
   } rsp_type;

endpackage

[rtl/i2cm_seq.sv]
module i2cm_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  i2cm_pkg::cfg_type cfg,
   input  i2cm_pkg::req_type req,
   output i2cm_pkg::rsp_type rsp
);
   import i2cm_pkg::*;

   phase_type   phase_ff, phase_in;
   kind_type    kind_ff, kind_in;
   err_type     perr_ff, perr_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  reg_ff, reg_in;
   logic        is_read_ff, is_read_in;
   logic [7:0]  ackw_ff, ackw_in;

   logic [15:0] tick_inc;
   logic [15:0] phase_len;
   logic        fire;
   logic [3:0]  bit_inc;
   logic [7:0]  left_dec;
   logic [7:0]  count_clamped;

   assign tick_inc  = tick_ff + 16'd1;
   assign phase_len = (phase_ff == PH_RB_LO) ? cfg.read_low_ticks : cfg.half_period_ticks;
   // zero length acts as a single tick
   assign fire      = (phase_len == 16'd0) || (tick_inc >= phase_len);
   assign bit_inc   = bit_ff + 4'd1;
   assign left_dec  = left_ff - 8'd1;
   assign count_clamped = (17'(req.byte_count) > 17'(MAX_BYTES)) ?
                          8'(MAX_BYTES) : req.byte_count;

   // next state
   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      perr_in    = perr_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      left_in    = left_ff;
      reg_in     = reg_ff;
      is_read_in = is_read_ff;
      ackw_in    = ackw_ff;

      case (phase_ff)
         PH_IDLE: begin
            if (req.operation == OP_WRITE || req.operation == OP_READ) begin
               is_read_in = (req.operation == OP_READ);
               reg_in     = req.register_number;
               left_in    = count_clamped;
               kind_in    = KIND_ADDR;
               perr_in    = ERR_NONE;
               phase_in   = PH_ST_HI;
               tick_in    = '0;
            end
         end
         PH_ST_HI: begin
            tick_in = fire ? '0 : tick_inc;
            if (fire) phase_in = PH_ST_LO;
         end
         PH_ST_LO: begin
            tick_in = fire ? '0 : tick_inc;
            if (fire) begin
               shift_in = (kind_ff == KIND_RADDR) ? (cfg.device_address | 8'h01)
                                                  : cfg.device_address;
               bit_in   = '0;
               phase_in = PH_WB_LO;
            end
         end
         PH_RS_LO: begin
            tick_in = fire ? '0 : tick_inc;
            if (fire) phase_in = PH_ST_HI;
         end
         PH_WB_LO: begin
            tick_in = fire ? '0 : tick_inc;
            if (fire) phase_in = PH_WB_HI;
         end
         PH_WB_HI: begin
            tick_in = fire ? '0 : tick_inc;
            if (fire) begin
               shift_in = {shift_ff[6:0], 1'b0};
               bit_in   = bit_inc;
               phase_in = (bit_inc >= 4'd8) ? PH_ACK_LO : PH_WB_LO;
            end
         end
         PH_ACK_LO: begin
            tick_in = fire ? '0 : tick_inc;
            if (fire) begin
               ackw_in  = '0;
               phase_in = PH_ACK_WAIT;
            end
         end
         PH_ACK_WAIT: begin
            if (!req.sda_in) begin
               tick_in = '0;
               case (kind_ff)
                  KIND_ADDR: begin
                     kind_in  = KIND_REG;
                     shift_in = reg_ff;
                     bit_in   = '0;
                     phase_in = PH_WB_LO;
                  end
                  KIND_REG: begin
                     if (is_read_ff) begin
                        kind_in  = KIND_RADDR;
                        phase_in = PH_RS_LO;
                     end else begin
                        phase_in = (left_ff != 8'd0) ? PH_NEED : PH_SP_LO;
                     end
                  end
                  KIND_DATA: begin
                     left_in  = left_dec;
                     phase_in = (left_dec != 8'd0) ? PH_NEED : PH_SP_LO;
                  end
                  default: begin
                     if (left_ff != 8'd0) begin
                        shift_in = '0;
                        bit_in   = '0;
                        phase_in = PH_RB_LO;
                     end else begin
                        phase_in = PH_SP_LO;
                     end
                  end
               endcase
            end else if (ackw_ff >= cfg.ack_timeout_ticks) begin
               case (kind_ff)
                  KIND_REG:  perr_in = ERR_REG;
                  KIND_DATA: perr_in = ERR_DATA;
                  default:   perr_in = ERR_ADDR;
               endcase
               tick_in  = '0;
               phase_in = PH_SP_LO;
            end else begin
               ackw_in = ackw_ff + 8'd1;
            end
         end
         PH_NEED: begin
            if (req.operation == OP_DATA) begin
               kind_in  = KIND_DATA;
               shift_in = req.write_data;
               bit_in   = '0;
               tick_in  = '0;
               phase_in = PH_WB_LO;
            end
         end
         PH_RB_LO: begin
            tick_in = fire ? '0 : tick_inc;
            if (fire) phase_in = PH_RB_HI;
         end
         PH_RB_HI: begin
            shift_in = {shift_ff[6:0], req.sda_in};
            bit_in   = bit_inc;
            tick_in  = '0;
            if (bit_inc >= 4'd8) begin
               left_in  = left_dec;
               phase_in = PH_MA_LO;
            end else begin
               phase_in = PH_RB_LO;
            end
         end
         PH_MA_LO: begin
            tick_in = fire ? '0 : tick_inc;
            if (fire) phase_in = PH_MA_HI;
         end
         PH_MA_HI: begin
            tick_in = fire ? '0 : tick_inc;
            if (fire) begin
               if (left_ff != 8'd0) begin
                  shift_in = '0;
                  bit_in   = '0;
                  phase_in = PH_RB_LO;
               end else begin
                  phase_in = PH_SP_LO;
               end
            end
         end
         PH_SP_LO: begin
            tick_in = fire ? '0 : tick_inc;
            if (fire) phase_in = PH_SP_HI;
         end
         PH_SP_HI: begin
            tick_in = fire ? '0 : tick_inc;
            if (fire) phase_in = PH_IDLE;
         end
         default: begin
            tick_in  = '0;
            phase_in = PH_IDLE;
         end
      endcase
   end

   // outputs, from the state this tick moves into
   always_comb begin
      rsp = '0;
      case (phase_in)
         PH_ST_LO:  begin rsp.scl_level = 1'b1; rsp.sda_level = 1'b0;        end
         PH_RS_LO:  begin rsp.scl_level = 1'b0; rsp.sda_level = 1'b1;        end
         PH_WB_LO:  begin rsp.scl_level = 1'b0; rsp.sda_level = shift_in[7]; end
         PH_WB_HI:  begin rsp.scl_level = 1'b1; rsp.sda_level = shift_in[7]; end
         PH_ACK_LO: begin rsp.scl_level = 1'b0; rsp.sda_level = 1'b1;        end
         PH_NEED:   begin rsp.scl_level = 1'b0; rsp.sda_level = 1'b1;        end
         PH_RB_LO:  begin rsp.scl_level = 1'b0; rsp.sda_level = 1'b1;        end
         // master ACK, NAK after the last byte
         PH_MA_LO:  begin rsp.scl_level = 1'b0; rsp.sda_level = (left_in == 8'd0); end
         PH_MA_HI:  begin rsp.scl_level = 1'b1; rsp.sda_level = (left_in == 8'd0); end
         PH_SP_LO:  begin rsp.scl_level = 1'b0; rsp.sda_level = 1'b0;        end
         PH_SP_HI:  begin rsp.scl_level = 1'b1; rsp.sda_level = 1'b0;        end
         default:   begin rsp.scl_level = 1'b1; rsp.sda_level = 1'b1;        end
      endcase
      rsp.busy_res   = (phase_in != PH_IDLE);
      rsp.need_data  = (phase_in == PH_NEED);
      rsp.read_valid = (phase_ff == PH_RB_HI) && (phase_in == PH_MA_LO);
      rsp.read_data  = rsp.read_valid ? shift_in : 8'd0;
      rsp.read_last  = rsp.read_valid && (left_in == 8'd0);
      rsp.done_res   = (phase_ff == PH_SP_HI) && fire;
      rsp.error_code = rsp.done_res ? perr_ff : ERR_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         kind_ff    <= KIND_ADDR;
         perr_ff    <= ERR_NONE;
         tick_ff    <= '0;
         bit_ff     <= '0;
         shift_ff   <= '0;
         left_ff    <= '0;
         reg_ff     <= '0;
         is_read_ff <= 1'b0;
         ackw_ff    <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         perr_ff    <= perr_in;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         left_ff    <= left_in;
         reg_ff     <= reg_in;
         is_read_ff <= is_read_in;
         ackw_ff    <= ackw_in;
      end
   end

endmodule

[rtl/i2c_master_register_access_core.sv]
// Tick-driven I2C master for register reads and writes on one device.
// req channel: one word per bus tick, carrying the sampled SDA level and an
// optional request (start write, start read, or a write byte while need_data
// is shown). rsp channel: one word per accepted req word, with the SCL and
// SDA levels to drive from that tick on plus busy, read byte and done status.
// csr channel: register writes (device address, phase lengths, ACK timeout),
// always ready; write only while no req word is in flight.
// An accepted req word's rsp word is registered in the output register, or in
// the skid entry if that is full. Throughput: one req word per cycle while
// req_stall is low; the sequencer step is a single registered pass.
// When rsp is stalled, results collect in the output register and one skid
// entry; req_stall rises only once both hold a word, so no result is lost.
// Reset: sequencer idle (bus released, SCL and SDA high), registers to their
// defaults, output register and skid emptied.
module i2c_master_register_access_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_operation,
   input  logic [7:0]        req_register_number,
   input  logic [7:0]        req_byte_count,
   input  logic [7:0]        req_write_data,
   input  logic              req_sda_in,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_scl_level,
   output logic              rsp_sda_level,
   output logic              rsp_busy_res,
   output logic              rsp_need_data,
   output logic [7:0]        rsp_read_data,
   output logic              rsp_read_valid,
   output logic              rsp_read_last,
   output logic              rsp_done_res,
   output logic [1:0]        rsp_error_code,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  i2cm_pkg::csr_type csr_index,
   input  logic [15:0]       csr_data
);
   import i2cm_pkg::*;

   cfg_type cfg_ff;
   req_type step_req;
   rsp_type step_rsp;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    accept;
   logic    out_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address    <= DEVICE_ADDRESS_RESET;
         cfg_ff.half_period_ticks <= HALF_PERIOD_TICKS_RESET;
         cfg_ff.read_low_ticks    <= READ_LOW_TICKS_RESET;
         cfg_ff.ack_timeout_ticks <= ACK_TIMEOUT_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS:    cfg_ff.device_address    <= csr_data[7:0];
            CSR_HALF_PERIOD_TICKS: cfg_ff.half_period_ticks <= csr_data;
            CSR_READ_LOW_TICKS:    cfg_ff.read_low_ticks    <= csr_data;
            CSR_ACK_TIMEOUT_TICKS: cfg_ff.ack_timeout_ticks <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign step_req.operation       = op_type'(req_operation);
   assign step_req.register_number = req_register_number;
   assign step_req.byte_count      = req_byte_count;
   assign step_req.write_data      = req_write_data;
   assign step_req.sda_in          = req_sda_in;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_pop   = out_valid_ff && !rsp_stall;

   i2cm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (accept),
      .cfg     (cfg_ff),
      .req     (step_req),
      .rsp     (step_rsp)
   );

   // output register plus one skid word
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = step_rsp;
            out_valid_in = accept;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_in       = step_rsp;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = step_rsp;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_scl_level  = out_ff.scl_level;
   assign rsp_sda_level  = out_ff.sda_level;
   assign rsp_busy_res   = out_ff.busy_res;
   assign rsp_need_data  = out_ff.need_data;
   assign rsp_read_data  = out_ff.read_data;
   assign rsp_read_valid = out_ff.read_valid;
   assign rsp_read_last  = out_ff.read_last;
   assign rsp_done_res   = out_ff.done_res;
   assign rsp_error_code = 2'(out_ff.error_code);

endmodule

[rtl/i2cm_checker.sv]
`include "i2c_master_register_access_core_defines.svh"

module i2cm_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_scl_level,
   input logic              rsp_sda_level,
   input logic              rsp_busy_res,
   input logic              rsp_need_data,
   input logic [7:0]        rsp_read_data,
   input logic              rsp_read_valid,
   input logic              rsp_read_last,
   input logic              rsp_done_res,
   input logic [1:0]        rsp_error_code
);

   // a stalled result word holds
   `I2CM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable({rsp_scl_level, rsp_sda_level, rsp_busy_res, rsp_need_data,
         rsp_read_data, rsp_read_valid, rsp_read_last, rsp_done_res, rsp_error_code}),
      "rsp word changed while stalled")

   // idle bus is released
   `I2CM_ASSERT_NOW(a_idle_released, rsp_valid && !rsp_busy_res,
      rsp_scl_level && rsp_sda_level, "bus driven while idle")

   `I2CM_ASSERT_NOW(a_need_scl_low, rsp_valid && rsp_need_data,
      rsp_busy_res && !rsp_scl_level && rsp_sda_level, "need_data without SCL held low")

   `I2CM_ASSERT_NOW(a_read_fields, rsp_valid && !rsp_read_valid,
      rsp_read_data == 8'd0 && !rsp_read_last, "read fields set without read_valid")

   `I2CM_ASSERT_NOW(a_error_on_done, rsp_valid && !rsp_done_res,
      rsp_error_code == 2'd0 && !(rsp_read_valid && !rsp_busy_res), "error code outside done")

endmodule

bind i2c_master_register_access_core i2cm_checker u_checker (.*);
